[sv/bsgs_pkg.sv]
// Package: widths, sizes, status codes and sequencer states for the gap scheduler.
package bsgs_pkg;
  localparam int GapSlots   = 16;
  localparam int QueueSlots = 16;
  localparam int TimeBits   = 48;
  localparam int GapIdxW    = $clog2(GapSlots);
  localparam int QIdxW      = (QueueSlots > 1) ? $clog2(QueueSlots) : 1;
  localparam int LatW       = 16;
  localparam int DelayW     = 32;
  localparam int CallerW    = 8;
  localparam int StatusW    = 3;
  localparam logic [TimeBits-1:0] TimeMax = '1;

  typedef enum logic [StatusW-1:0] {
    StGranted   = 3'd0,
    StCompleted = 3'd1,
    StGapFull   = 3'd2,
    StQueueFull = 3'd3,
    StQueueEmpty= 3'd4
  } status_e;

  typedef enum logic [3:0] {
    SIdle, SPrune, SRaise, SScan, SQScan, SCommit, SCompScan, SCompDone, SOut
  } state_e;

  // Saturating time add.
  function automatic logic [TimeBits-1:0] sat_add(logic [TimeBits-1:0] a,
                                                  logic [TimeBits-1:0] b);
    logic [TimeBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeBits] ? TimeMax : s[TimeBits-1:0];
  endfunction
endpackage

[sv/bus_slot_gap_scheduler.sv]
// Top level: gap-table slot scheduler with a sequential scan engine.
//
//  channel | valid    | stall    | payload
//  --------+----------+----------+-----------------------------------------
//  config  | cfg_we_i | -        | cfg_data_i (transfer_latency)
//  input   | valid_i  | stall_o  | cmd_i now_i request_delay_i caller_id_i
//  output  | valid_o  | stall_i  | status_o granted_delay_o done_caller_id_o
//
// A schedule beat walks the gap table once to prune, raises the start of the
// earliest-ending surviving gap to now, walks the gap table once more to pick
// the best gap, then walks the queue for a free slot, then commits. A
// completion beat walks the queue once, then settles its result.
// Every walk visits one entry per cycle.
// Reset leaves one gap [0, all ones] and an empty queue; no clearing pass.
// stall_o is high from acceptance until the result beat is taken.
module bus_slot_gap_scheduler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bsgs_pkg::LatW-1:0]    cfg_data_i,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic                         cmd_i,
  input  logic [bsgs_pkg::TimeBits-1:0] now_i,
  input  logic [bsgs_pkg::DelayW-1:0]  request_delay_i,
  input  logic [bsgs_pkg::CallerW-1:0] caller_id_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [bsgs_pkg::StatusW-1:0] status_o,
  output logic [bsgs_pkg::TimeBits-1:0] granted_delay_o,
  output logic [bsgs_pkg::CallerW-1:0] done_caller_id_o
);
  localparam int TB = bsgs_pkg::TimeBits;
  localparam int GW = bsgs_pkg::GapIdxW;
  localparam int QW = bsgs_pkg::QIdxW;
  localparam int GN = bsgs_pkg::GapSlots;
  localparam int QN = bsgs_pkg::QueueSlots;

  bsgs_pkg::state_e state_q, state_d;

  logic [bsgs_pkg::LatW-1:0] lat_q;
  logic [TB-1:0] lat_t;
  assign lat_t = TB'(lat_q);

  // Gap table and queue (16 entries each, one entry visited per cycle during walks).
  logic [TB-1:0] gs_q [GN];
  logic [TB-1:0] ge_q [GN];
  logic [GN-1:0] gv_q;
  logic [TB-1:0] ps_q [QN];
  logic [bsgs_pkg::CallerW-1:0] pc_q [QN];
  logic [QN-1:0] pv_q;

  // Item registers.
  logic [TB-1:0] now_q, limit_q, req_q;
  logic [bsgs_pkg::CallerW-1:0] caller_q;

  // Scan state.
  logic [GW:0]   gi_q;        // gap walk counter
  logic [QW:0]   qi_q;        // queue walk counter
  logic          found_q, freeg_ok_q, freeq_ok_q;
  logic [GW-1:0] best_q, freeg_q;
  logic [QW-1:0] freeq_q, qbest_q;
  logic [TB-1:0] best_end_q, s_q, e_q;

  // Result.
  logic [bsgs_pkg::StatusW-1:0] st_q;
  logic [TB-1:0] gd_q;
  logic [bsgs_pkg::CallerW-1:0] dc_q;

  logic [GW-1:0] gidx;
  logic [QW-1:0] qidx;
  assign gidx = gi_q[GW-1:0];
  assign qidx = qi_q[QW-1:0];

  logic gap_last, q_last;
  assign gap_last = (gi_q == (GW+1)'(GN-1));
  assign q_last   = (qi_q == (QW+1)'(QN-1));

  // Shared unit: candidate start/end for the current gap.
  logic [TB-1:0] cur_s, cur_e, ts, te;
  assign cur_s = gs_q[gidx];
  assign cur_e = ge_q[gidx];
  assign ts = (req_q > cur_s) ? req_q : cur_s;
  assign te = bsgs_pkg::sat_add(ts, lat_t);

  logic accept_in, accept_out;
  assign accept_in  = valid_i && !stall_o;
  assign accept_out = valid_o && !stall_i;

  // Split decisions for the chosen gap.
  logic keep_l, keep_r;
  assign keep_l = (s_q - gs_q[best_q]) >= lat_t;
  assign keep_r = (ge_q[best_q] - e_q) >= lat_t;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsgs_pkg::SIdle:
        if (accept_in) state_d = cmd_i ? bsgs_pkg::SCompScan : bsgs_pkg::SPrune;
      bsgs_pkg::SPrune: if (gap_last) state_d = bsgs_pkg::SRaise;
      bsgs_pkg::SRaise: state_d = bsgs_pkg::SScan;
      bsgs_pkg::SScan:  if (gap_last) state_d = bsgs_pkg::SQScan;
      bsgs_pkg::SQScan: if (q_last) state_d = bsgs_pkg::SCommit;
      bsgs_pkg::SCommit: state_d = bsgs_pkg::SOut;
      bsgs_pkg::SCompScan: if (q_last) state_d = bsgs_pkg::SCompDone;
      bsgs_pkg::SCompDone: state_d = bsgs_pkg::SOut;
      bsgs_pkg::SOut: if (accept_out) state_d = bsgs_pkg::SIdle;
      default: state_d = bsgs_pkg::SIdle;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    stall_o = (state_q != bsgs_pkg::SIdle);
    valid_o = (state_q == bsgs_pkg::SOut);
  end
  assign status_o         = st_q;
  assign granted_delay_o  = gd_q;
  assign done_caller_id_o = dc_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsgs_pkg::SIdle;
      lat_q   <= bsgs_pkg::LatW'(4);
      gv_q    <= GN'(1);
      pv_q    <= '0;
      gi_q    <= '0;
      qi_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) lat_q <= cfg_data_i;
      gi_q <= (state_q == bsgs_pkg::SPrune || state_q == bsgs_pkg::SScan) ?
              gi_q + 1'b1 : '0;
      qi_q <= (state_q == bsgs_pkg::SQScan || state_q == bsgs_pkg::SCompScan) ?
              qi_q + 1'b1 : '0;
      if (state_q == bsgs_pkg::SPrune && gv_q[gidx] && cur_e < limit_q) gv_q[gidx] <= 1'b0;
      if (state_q == bsgs_pkg::SCommit && st_q == bsgs_pkg::StGranted) begin
        pv_q[freeq_q] <= 1'b1;
        if (keep_l && keep_r) gv_q[freeg_q] <= 1'b1;
        else if (!keep_l && !keep_r) gv_q[best_q] <= 1'b0;
      end
      if (state_q == bsgs_pkg::SCompDone && found_q) pv_q[qbest_q] <= 1'b0;
    end
  end

  // Gap bounds: entry 0 spans all time after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GN; i++) begin
        gs_q[i] <= '0;
        ge_q[i] <= (i == 0) ? bsgs_pkg::TimeMax : '0;
      end
    end else begin
      unique case (state_q)
        bsgs_pkg::SRaise: begin
          if (found_q && gs_q[best_q] < now_q) gs_q[best_q] <= now_q;
        end
        bsgs_pkg::SCommit: begin
          if (st_q == bsgs_pkg::StGranted) begin
            if (keep_l && keep_r) begin
              gs_q[freeg_q] <= gs_q[best_q];
              ge_q[freeg_q] <= s_q;
              gs_q[best_q]  <= e_q;
            end else if (keep_l) begin
              ge_q[best_q] <= s_q;
            end else if (keep_r) begin
              gs_q[best_q] <= e_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload and scan registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      bsgs_pkg::SIdle: if (accept_in) begin
        now_q    <= now_i;
        caller_q <= caller_id_i;
        limit_q  <= bsgs_pkg::sat_add(now_i, lat_t);
        req_q    <= bsgs_pkg::sat_add(now_i, TB'(request_delay_i));
        found_q  <= 1'b0;
        freeg_ok_q <= 1'b0;
        freeq_ok_q <= 1'b0;
      end
      bsgs_pkg::SPrune: begin
        // track earliest-ending survivor
        if (gv_q[gidx] && !(cur_e < limit_q) && (!found_q || cur_e < best_end_q)) begin
          found_q <= 1'b1; best_q <= gidx; best_end_q <= cur_e;
        end
      end
      bsgs_pkg::SRaise: begin
        found_q <= 1'b0;
      end
      bsgs_pkg::SScan: begin
        if (!gv_q[gidx]) begin
          if (!freeg_ok_q) begin freeg_ok_q <= 1'b1; freeg_q <= gidx; end
        end else if (!(te > cur_e) && (!found_q || cur_e < best_end_q)) begin
          found_q <= 1'b1; best_q <= gidx; best_end_q <= cur_e;
          s_q <= ts; e_q <= te;
        end
      end
      bsgs_pkg::SQScan: begin
        if (!pv_q[qidx] && !freeq_ok_q) begin freeq_ok_q <= 1'b1; freeq_q <= qidx; end
      end
      bsgs_pkg::SCommit: begin
        if (st_q == bsgs_pkg::StGranted) begin
          ps_q[freeq_q] <= s_q;
          pc_q[freeq_q] <= caller_q;
        end else begin
          gd_q <= '0;
        end
      end
      bsgs_pkg::SCompScan: begin
        if (pv_q[qidx] && (!found_q || ps_q[qidx] < best_end_q)) begin
          found_q <= 1'b1; qbest_q <= qidx; best_end_q <= ps_q[qidx];
        end
      end
      bsgs_pkg::SCompDone: begin
        st_q <= found_q ? bsgs_pkg::StCompleted : bsgs_pkg::StQueueEmpty;
        dc_q <= found_q ? pc_q[qbest_q] : '0;
        gd_q <= '0;
      end
      default: ;
    endcase
    // Status for schedule is settled at the end of the queue walk.
    if (state_q == bsgs_pkg::SQScan && q_last) begin
      dc_q <= '0;
      gd_q <= s_q - now_q;
      if (!found_q) st_q <= bsgs_pkg::StGapFull;
      else if (keep_l && keep_r && !freeg_ok_q) st_q <= bsgs_pkg::StGapFull;
      else if (!freeq_ok_q && pv_q[qidx]) st_q <= bsgs_pkg::StQueueFull;
      else st_q <= bsgs_pkg::StGranted;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> stall_o) else $error("result while accepting");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsgs_pkg::SCommit && st_q == bsgs_pkg::StGranted) |=> pv_q != '0)
    else $error("grant without queue entry");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != bsgs_pkg::StGranted) |-> granted_delay_o == '0)
    else $error("delay on non-grant");
endmodule
